[rtl/similarity_transform_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the similarity transform unit
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SIMILARITY_TRANSFORM_UNIT_ASSERT_SVH
`define SIMILARITY_TRANSFORM_UNIT_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define STU_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition implies consequence in the next cycle.
`define STU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/stu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stu_pkg
// Types and constants shared by the similarity transform unit modules.
// ----------------------------------------------------------------------------
package stu_pkg;

    localparam int COORD_BITS_DEF    = 24;
    localparam int ROT_FRAC_BITS_DEF = 14;
    localparam int SCALE_W           = 16;
    localparam int SCALE_FRAC        = 8;
    localparam int CFG_IDX_W         = 3;
    localparam int NUM_AXES          = 3;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

    typedef enum logic [1:0] {
        REQ_POINT,
        REQ_VECTOR,
        REQ_DIRECTION,
        REQ_BOX
    } req_type_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCALE,
        CFG_ROT_ROW0,
        CFG_ROT_ROW1,
        CFG_ROT_ROW2,
        CFG_TRANS_X,
        CFG_TRANS_Y,
        CFG_TRANS_Z
    } cfg_reg_t;

    typedef struct packed {
        req_type_t req_type;
        logic      ident;
    } ctrl_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } pipe_en_t;

endpackage

[rtl/stu_scale_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stu_scale_lane
// One axis: scales the item and forms the rotation operands (two stages).
// ----------------------------------------------------------------------------
module stu_scale_lane
    import stu_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int UW        = COORD_BITS + 9
)
(
    input  logic                         clk,
    input  pipe_en_t                     en,
    input  ctrl_t                        ctrl,
    input  logic [SCALE_W-1:0]           scale,
    input  logic signed [COORD_BITS-1:0] a,
    input  logic signed [COORD_BITS-1:0] b,
    output logic signed [UW-1:0]         u,
    output logic signed [UW-1:0]         w
);

    localparam int PW = COORD_BITS + SCALE_W + 1;
    localparam logic signed [PW:0]   HALF8 = (PW+1)'(1) << (SCALE_FRAC - 1);
    localparam logic signed [PW+1:0] HALF9 = (PW+2)'(1) << SCALE_FRAC;

    logic signed [SCALE_W:0]         s_ext;
    logic signed [PW-1:0]            as_reg, bs_reg;
    logic signed [COORD_BITS-1:0]    a_reg;
    logic signed [PW:0]              as_h, bs_h;
    logic signed [PW+1:0]            sum_h, dif_h;
    logic signed [UW-1:0]            u8, b8, c9, w9;
    logic signed [UW-1:0]            u_next, w_next;
    logic signed [UW-1:0]            u_reg, w_reg;

    assign s_ext = {1'b0, scale};

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            as_reg <= PW'(a) * PW'(s_ext);
            bs_reg <= PW'(b) * PW'(s_ext);
            a_reg  <= a;
        end
    end

    always_comb
    begin
        as_h  = (PW+1)'(as_reg) + HALF8;
        bs_h  = (PW+1)'(bs_reg) + HALF8;
        sum_h = (PW+2)'(as_reg) + (PW+2)'(bs_reg) + HALF9;
        dif_h = (PW+2)'(bs_reg) - (PW+2)'(as_reg) + HALF9;
        u8    = UW'(as_h >>> SCALE_FRAC);
        b8    = UW'(bs_h >>> SCALE_FRAC);
        // box centre and half-width drop one extra bit for the halving
        c9    = UW'(sum_h >>> (SCALE_FRAC + 1));
        w9    = UW'(dif_h >>> (SCALE_FRAC + 1));
        case (ctrl.req_type)
            REQ_DIRECTION:
            begin
                u_next = UW'(a_reg);
                w_next = '0;
            end
            REQ_BOX:
            begin
                u_next = ctrl.ident ? u8 : c9;
                w_next = ctrl.ident ? b8 : w9;
            end
            default:
            begin
                u_next = u8;
                w_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            u_reg <= u_next;
            w_reg <= w_next;
        end
    end

    assign u = u_reg;
    assign w = w_reg;

endmodule

[rtl/stu_rot_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stu_rot_lane
// One output axis: rotation column products, rounding, translate, saturate.
// ----------------------------------------------------------------------------
module stu_rot_lane
    import stu_pkg::*;
#(
    parameter int COORD_BITS    = COORD_BITS_DEF,
    parameter int ROT_FRAC_BITS = ROT_FRAC_BITS_DEF,
    localparam int UW           = COORD_BITS + 9,
    localparam int RW           = ROT_FRAC_BITS + 2
)
(
    input  logic                         clk,
    input  pipe_en_t                     en,
    input  ctrl_t                        ctrl,
    input  logic signed [UW-1:0]         u [NUM_AXES],
    input  logic signed [UW-1:0]         w [NUM_AXES],
    input  logic signed [UW-1:0]         u_self,
    input  logic signed [UW-1:0]         w_self,
    input  logic signed [RW-1:0]         r_col [NUM_AXES],
    input  logic signed [COORD_BITS-1:0] trans,
    output logic signed [COORD_BITS-1:0] res_a,
    output logic signed [COORD_BITS-1:0] res_b,
    output logic                         clip
);

    localparam int MW  = UW + RW + 1;
    localparam int SW  = MW + 3;
    localparam int RSW = SW - ROT_FRAC_BITS;
    localparam int FW  = RSW + 2;
    localparam logic signed [SW-1:0] RND_HALF = SW'(1) << (ROT_FRAC_BITS - 1);
    localparam logic signed [FW-1:0] SAT_HI   = (FW'(1) << (COORD_BITS - 1)) - FW'(1);
    localparam logic signed [FW-1:0] SAT_LO   = ~SAT_HI;

    logic signed [RW:0]     r_abs [NUM_AXES];
    logic signed [MW-1:0]   pu_reg [NUM_AXES];
    logic signed [MW-1:0]   pw_reg [NUM_AXES];
    logic signed [UW-1:0]   us_reg, ws_reg;
    logic signed [SW-1:0]   su, sw;
    logic signed [RSW-1:0]  rc_next, rw_next, rc_reg, rw_reg;
    logic signed [FW-1:0]   rc_x, rw_x, t_x, base, ra, rb;
    logic                   clip_a, clip_b;

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            r_abs[i] = r_col[i][RW-1] ? -((RW+1)'(r_col[i])) : (RW+1)'(r_col[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                pu_reg[i] <= MW'(u[i]) * MW'(r_col[i]);
                pw_reg[i] <= MW'(w[i]) * MW'(r_abs[i]);
            end
            us_reg <= u_self;
            ws_reg <= w_self;
        end
    end

    always_comb
    begin
        su = SW'(pu_reg[0]) + SW'(pu_reg[1]) + SW'(pu_reg[2]) + RND_HALF;
        sw = SW'(pw_reg[0]) + SW'(pw_reg[1]) + SW'(pw_reg[2]) + RND_HALF;
        // identity rotation: pass the scaled operands straight through
        rc_next = ctrl.ident ? RSW'(us_reg) : RSW'(su >>> ROT_FRAC_BITS);
        rw_next = ctrl.ident ? RSW'(ws_reg) : RSW'(sw >>> ROT_FRAC_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            rc_reg <= rc_next;
            rw_reg <= rw_next;
        end
    end

    always_comb
    begin
        rc_x = FW'(rc_reg);
        rw_x = FW'(rw_reg);
        t_x  = FW'(trans);
        if (ctrl.req_type == REQ_POINT || ctrl.req_type == REQ_BOX)
        begin
            base = rc_x + t_x;
        end
        else
        begin
            base = rc_x;
        end
        if (ctrl.req_type == REQ_BOX)
        begin
            if (ctrl.ident)
            begin
                ra = base;
                rb = rw_x + t_x;
            end
            else
            begin
                ra = base - rw_x;
                rb = base + rw_x;
            end
        end
        else
        begin
            ra = base;
            rb = '0;
        end

        clip_a = 1'b0;
        clip_b = 1'b0;
        if (ra > SAT_HI)
        begin
            res_a  = COORD_BITS'(SAT_HI);
            clip_a = 1'b1;
        end
        else if (ra < SAT_LO)
        begin
            res_a  = COORD_BITS'(SAT_LO);
            clip_a = 1'b1;
        end
        else
        begin
            res_a = COORD_BITS'(ra);
        end
        if (rb > SAT_HI)
        begin
            res_b  = COORD_BITS'(SAT_HI);
            clip_b = 1'b1;
        end
        else if (rb < SAT_LO)
        begin
            res_b  = COORD_BITS'(SAT_LO);
            clip_b = 1'b1;
        end
        else
        begin
            res_b = COORD_BITS'(rb);
        end
        clip = clip_a | clip_b;
    end

endmodule

[rtl/stu_merge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stu_merge
// Combines the three lane results into one output item and holds it.
// ----------------------------------------------------------------------------
module stu_merge
    import stu_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int DATA_W    = ((6 * COORD_BITS + 7) / 8) * 8
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         vld,
    input  logic                         last,
    input  logic signed [COORD_BITS-1:0] res_a [NUM_AXES],
    input  logic signed [COORD_BITS-1:0] res_b [NUM_AXES],
    input  logic [NUM_AXES-1:0]          clip,
    output logic                         ready,
    output logic                         tvalid,
    input  logic                         tready,
    output logic [DATA_W-1:0]            tdata,
    output logic                         tuser,
    output logic                         tlast
);

    logic              valid_reg;
    logic [DATA_W-1:0] data_next, data_reg;
    logic              clip_reg, last_reg;

    assign ready = !valid_reg || tready;

    always_comb
    begin
        data_next = '0;
        for (int k = 0; k < NUM_AXES; k++)
        begin
            data_next[k*COORD_BITS +: COORD_BITS]              = res_a[k];
            data_next[(NUM_AXES+k)*COORD_BITS +: COORD_BITS]   = res_b[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready)
        begin
            data_reg <= data_next;
            clip_reg <= |clip;
            last_reg <= last;
        end
    end

    assign tvalid = valid_reg;
    assign tdata  = data_reg;
    assign tuser  = clip_reg;
    assign tlast  = last_reg;

endmodule

[rtl/similarity_transform_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// similarity_transform_unit
// Scale, rotate and translate of points, vectors, directions and boxes.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: cfg_wr_en/cfg_index/cfg_data write scale, the three rotation
//   rows and the translation; write only while no item is in flight.
//   Input stream s_*: s_tdata holds a_x, a_y, a_z, b_x, b_y, b_z from the lowest
//   bit up, s_tuser the request type, s_tlast the batch mark.
//   Output stream m_*: m_tdata holds out_a_x..out_b_z, m_tuser the clipped flag,
//   m_tlast the copied batch mark.
//   An item passes stage registers s1..s4 and the output register to m_tvalid;
//   throughput is one item per cycle while m_tready is high, set by the fully pipelined
//   scale and rotation lanes (three axes side by side, one multiplier per product).
//   Reset empties the pipeline and loads scale 1.0, identity rotation and zero
//   translation.
//   When m_tready is low the output item is held; each pipeline stage keeps
//   taking items until it is full, then s_tready drops.
// ----------------------------------------------------------------------------
`include "similarity_transform_unit_assert.svh"

module similarity_transform_unit
    import stu_pkg::*;
#(
    parameter int COORD_BITS    = COORD_BITS_DEF,
    parameter int ROT_FRAC_BITS = ROT_FRAC_BITS_DEF,
    localparam int RW           = ROT_FRAC_BITS + 2,
    localparam int DATA_W       = ((6 * COORD_BITS + 7) / 8) * 8,
    localparam int CFG_W        = (3 * RW > COORD_BITS) ? 3 * RW : COORD_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [DATA_W-1:0]     s_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z, zero pad
    input  logic [1:0]            s_tuser,   // req_type
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [DATA_W-1:0]     m_tdata,   // out_a_x, out_a_y, out_a_z, out_b_x..z, pad
    output logic                  m_tuser,   // clipped
    output logic                  m_tlast
);

    localparam int UW = COORD_BITS + 9;
    localparam logic signed [RW-1:0] ID_THR = (RW'(1) << ROT_FRAC_BITS) - RW'(2);

    logic [SCALE_W-1:0]           scale_reg;
    logic [3*RW-1:0]              rot_reg [NUM_AXES];
    logic signed [COORD_BITS-1:0] trans_reg [NUM_AXES];
    logic                         ident;

    logic [3:0]                   vld_reg;
    req_type_t                    type_reg [4];
    logic [3:0]                   last_reg;
    logic                         rdy1, rdy2, rdy3, rdy4, rdy5;
    pipe_en_t                     en;
    ctrl_t                        st1_ctrl, st4_ctrl;

    logic signed [COORD_BITS-1:0] a_in [NUM_AXES];
    logic signed [COORD_BITS-1:0] b_in [NUM_AXES];
    logic signed [UW-1:0]         u_w [NUM_AXES];
    logic signed [UW-1:0]         w_w [NUM_AXES];
    logic signed [COORD_BITS-1:0] res_a [NUM_AXES];
    logic signed [COORD_BITS-1:0] res_b [NUM_AXES];
    logic [NUM_AXES-1:0]          clip;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg    <= SCALE_RESET;
            rot_reg[0]   <= (3*RW)'(1) << ROT_FRAC_BITS;
            rot_reg[1]   <= (3*RW)'(1) << (ROT_FRAC_BITS + RW);
            rot_reg[2]   <= (3*RW)'(1) << (ROT_FRAC_BITS + 2*RW);
            trans_reg[0] <= '0;
            trans_reg[1] <= '0;
            trans_reg[2] <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_SCALE:    scale_reg    <= cfg_data[SCALE_W-1:0];
                CFG_ROT_ROW0: rot_reg[0]   <= cfg_data[3*RW-1:0];
                CFG_ROT_ROW1: rot_reg[1]   <= cfg_data[3*RW-1:0];
                CFG_ROT_ROW2: rot_reg[2]   <= cfg_data[3*RW-1:0];
                CFG_TRANS_X:  trans_reg[0] <= cfg_data[COORD_BITS-1:0];
                CFG_TRANS_Y:  trans_reg[1] <= cfg_data[COORD_BITS-1:0];
                CFG_TRANS_Z:  trans_reg[2] <= cfg_data[COORD_BITS-1:0];
                default:      ;
            endcase
        end
    end

    // skip rotation when R00 and R11 are both no lower than one step below one
    assign ident = ($signed(rot_reg[0][RW-1:0]) > ID_THR) &&
                   ($signed(rot_reg[1][RW +: RW]) > ID_THR);

    // stage handshake: a stage advances when empty or when its successor does
    assign rdy4     = !vld_reg[3] || rdy5;
    assign rdy3     = !vld_reg[2] || rdy4;
    assign rdy2     = !vld_reg[1] || rdy3;
    assign rdy1     = !vld_reg[0] || rdy2;
    assign s_tready = rdy1;
    assign en       = '{s1: rdy1, s2: rdy2, s3: rdy3, s4: rdy4};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy1) vld_reg[0] <= s_tvalid;
            if (rdy2) vld_reg[1] <= vld_reg[0];
            if (rdy3) vld_reg[2] <= vld_reg[1];
            if (rdy4) vld_reg[3] <= vld_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            type_reg[0] <= req_type_t'(s_tuser);
            last_reg[0] <= s_tlast;
        end
        if (rdy2)
        begin
            type_reg[1] <= type_reg[0];
            last_reg[1] <= last_reg[0];
        end
        if (rdy3)
        begin
            type_reg[2] <= type_reg[1];
            last_reg[2] <= last_reg[1];
        end
        if (rdy4)
        begin
            type_reg[3] <= type_reg[2];
            last_reg[3] <= last_reg[2];
        end
    end

    assign st1_ctrl = '{req_type: type_reg[0], ident: ident};
    assign st4_ctrl = '{req_type: type_reg[3], ident: ident};

    genvar k;
    generate
        for (k = 0; k < NUM_AXES; k++)
        begin : g_lane
            logic signed [RW-1:0] r_col [NUM_AXES];

            assign a_in[k]  = s_tdata[k*COORD_BITS +: COORD_BITS];
            assign b_in[k]  = s_tdata[(NUM_AXES+k)*COORD_BITS +: COORD_BITS];
            assign r_col[0] = rot_reg[0][k*RW +: RW];
            assign r_col[1] = rot_reg[1][k*RW +: RW];
            assign r_col[2] = rot_reg[2][k*RW +: RW];

            stu_scale_lane #(
                .COORD_BITS (COORD_BITS)
            ) u_scale (
                .clk   (clk),
                .en    (en),
                .ctrl  (st1_ctrl),
                .scale (scale_reg),
                .a     (a_in[k]),
                .b     (b_in[k]),
                .u     (u_w[k]),
                .w     (w_w[k])
            );

            stu_rot_lane #(
                .COORD_BITS    (COORD_BITS),
                .ROT_FRAC_BITS (ROT_FRAC_BITS)
            ) u_rot (
                .clk    (clk),
                .en     (en),
                .ctrl   (st4_ctrl),
                .u      (u_w),
                .w      (w_w),
                .u_self (u_w[k]),
                .w_self (w_w[k]),
                .r_col  (r_col),
                .trans  (trans_reg[k]),
                .res_a  (res_a[k]),
                .res_b  (res_b[k]),
                .clip   (clip[k])
            );
        end
    endgenerate

    stu_merge #(
        .COORD_BITS (COORD_BITS)
    ) u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .vld    (vld_reg[3]),
        .last   (last_reg[3]),
        .res_a  (res_a),
        .res_b  (res_b),
        .clip   (clip),
        .ready  (rdy5),
        .tvalid (m_tvalid),
        .tready (m_tready),
        .tdata  (m_tdata),
        .tuser  (m_tuser),
        .tlast  (m_tlast)
    );

    `STU_ASSERT_HOLDS(a_ready_when_out_empty, !m_tvalid, s_tready, "input blocked, output empty")
    `STU_ASSERT_NEXT(a_accept_fills_stage1, s_tvalid && s_tready, vld_reg[0], "accepted item lost")
    `STU_ASSERT_NEXT(a_drain_to_output, vld_reg[3] && !m_tvalid, m_tvalid, "result not moved to output")

endmodule

[tb/sv/tb_similarity_transform_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_similarity_transform_unit
// Checks scale/rotate/translate results for points, vectors, directions and
// boxes against a cycle-free predictor, across several register settings,
// with random idling on both streams and one long output back-pressure window.
// ----------------------------------------------------------------------------
module tb_similarity_transform_unit;
    import stu_pkg::*;

    localparam int CW   = COORD_BITS_DEF;
    localparam int RF   = ROT_FRAC_BITS_DEF;
    localparam int RW   = RF + 2;
    localparam int DW   = ((6 * CW + 7) / 8) * 8;
    localparam int CFGW = (3 * RW > CW) ? 3 * RW : CW;
    localparam int ONE  = 1 << RF;

    localparam longint COORD_MAX   = (longint'(1) <<< (CW - 1)) - 1;
    localparam longint COORD_MIN   = -COORD_MAX - 1;
    localparam longint IDENT_FLOOR = (longint'(1) <<< RF) - 2;
    localparam logic [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam int DRAIN_CYCLES = 16;

    typedef struct packed {
        req_type_t         kind;
        logic [2:0][CW-1:0] a;
        logic [2:0][CW-1:0] b;
        logic              last;
    } xform_req_t;

    typedef struct packed {
        logic [2:0][CW-1:0] lo;
        logic [2:0][CW-1:0] hi;
        logic              clipped;
        logic              last;
    } xform_res_t;

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFGW-1:0]   cfg_data  = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [DW-1:0]     s_tdata   = '0;   // a_x, a_y, a_z, b_x, b_y, b_z
    logic [1:0]        s_tuser   = '0;   // req_type
    logic              s_tlast   = 1'b0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [DW-1:0]     m_tdata;          // out_a_x, out_a_y, out_a_z, out_b_x, out_b_y, out_b_z
    logic              m_tuser;          // clipped
    logic              m_tlast;

    // predictor copy of the registers
    logic [SCALE_W-1:0] cur_scale;
    logic [3*RW-1:0]    cur_rot [3];
    logic [CW-1:0]      cur_trans [3];

    xform_req_t req_backlog [$];
    xform_res_t predicted_results [$];

    xform_req_t next_req;
    xform_req_t seen_req;
    xform_res_t seen_res;
    xform_res_t want_res;

    logic in_fire = 1'b0;
    int   src_gap = 0;
    int   snk_gap = 0;
    int   gap_odds = 0;
    int   snk_odds = 0;
    int   hold_left = 0;
    bit   backlog_done = 0;
    int   items_accepted = 0;
    int   box_count = 0;
    int   clipped_count = 0;
    int   results_seen = 0;
    int   setting_count = 1;
    int   mismatch_count = 0;
    string axis_tag = "xyz";

    similarity_transform_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1000000;
        $display("%t: timeout, %0d results still outstanding", $time,
                 predicted_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic longint round_half_up(longint x, int sh);
        return (x + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint rot_coef(int i, int j);
        logic signed [RW-1:0] e;
        e = cur_rot[i][j*RW +: RW];
        return longint'(e);
    endfunction

    function automatic logic [CW-1:0] clamp_coord(longint x);
        if (x > COORD_MAX)
            return C_MAX;
        if (x < COORD_MIN)
            return C_MIN;
        return x[CW-1:0];
    endfunction

    // row-vector times R, or times |R| for box half-widths
    function automatic void rotate_vec(input longint v [3], output longint o [3],
                                       input bit mag);
        longint acc;
        longint r;
        for (int j = 0; j < 3; j++)
        begin
            acc = 0;
            for (int i = 0; i < 3; i++)
            begin
                r = rot_coef(i, j);
                if (mag && r < 0)
                    r = -r;
                acc += v[i] * r;
            end
            o[j] = round_half_up(acc, RF);
        end
    endfunction

    function automatic xform_res_t predict_xform(xform_req_t q);
        xform_res_t r;
        longint a [3], b [3], t [3], v [3], c [3], w [3];
        longint rc [3], rw [3], ra [3], rb [3];
        longint s;
        bit ident, clip, is_box;
        r = '0;
        clip = 0;
        is_box = (q.kind == REQ_BOX);
        s = longint'(cur_scale);
        ident = rot_coef(0, 0) > IDENT_FLOOR && rot_coef(1, 1) > IDENT_FLOOR;
        for (int k = 0; k < 3; k++)
        begin
            a[k] = longint'($signed(q.a[k]));
            b[k] = longint'($signed(q.b[k]));
            t[k] = longint'($signed(cur_trans[k]));
            ra[k] = 0;
            rb[k] = 0;
        end
        if (is_box)
        begin
            if (ident)
            begin
                // identity: map each corner on its own
                for (int k = 0; k < 3; k++)
                begin
                    ra[k] = round_half_up(a[k] * s, SCALE_FRAC) + t[k];
                    rb[k] = round_half_up(b[k] * s, SCALE_FRAC) + t[k];
                end
            end
            else
            begin
                for (int k = 0; k < 3; k++)
                begin
                    c[k] = round_half_up((a[k] + b[k]) * s, SCALE_FRAC + 1);
                    w[k] = round_half_up((b[k] - a[k]) * s, SCALE_FRAC + 1);
                end
                rotate_vec(c, rc, 1'b0);
                rotate_vec(w, rw, 1'b1);
                for (int k = 0; k < 3; k++)
                begin
                    ra[k] = rc[k] + t[k] - rw[k];
                    rb[k] = rc[k] + t[k] + rw[k];
                end
            end
        end
        else
        begin
            for (int k = 0; k < 3; k++)
                v[k] = (q.kind == REQ_DIRECTION) ? a[k] : round_half_up(a[k] * s, SCALE_FRAC);
            if (ident)
            begin
                for (int k = 0; k < 3; k++)
                    ra[k] = v[k];
            end
            else
            begin
                rotate_vec(v, ra, 1'b0);
            end
            if (q.kind == REQ_POINT)
            begin
                for (int k = 0; k < 3; k++)
                    ra[k] += t[k];
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            if (ra[k] > COORD_MAX || ra[k] < COORD_MIN || rb[k] > COORD_MAX || rb[k] < COORD_MIN)
                clip = 1;
            r.lo[k] = clamp_coord(ra[k]);
            r.hi[k] = clamp_coord(rb[k]);
        end
        r.clipped = clip;
        r.last = q.last;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [CFGW-1:0] pack_row(int e0, int e1, int e2);
        return CFGW'({RW'(e2), RW'(e1), RW'(e0)});
    endfunction

    function automatic int rand_rot_entry(bit wide);
        if (wide)
            return int'($urandom_range(0, 65535)) - 32768;
        return int'($urandom_range(0, 2 * ONE)) - ONE;
    endfunction

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return C_MAX;
            1: return C_MIN;
            2: return CW'(int'($urandom_range(0, 2048)) - 1024);
            3, 4: return CW'(int'($urandom_range(0, 131072)) - 65536);
            default: return CW'($urandom);
        endcase
    endfunction

    task automatic add_item(req_type_t kind, logic [CW-1:0] ax, logic [CW-1:0] ay,
                            logic [CW-1:0] az, logic [CW-1:0] bx, logic [CW-1:0] by,
                            logic [CW-1:0] bz, logic last);
        xform_req_t q;
        q.kind = kind;
        q.a = {az, ay, ax};
        q.b = {bz, by, bx};
        q.last = last;
        req_backlog.push_back(q);
    endtask

    task automatic add_random_items(int n);
        xform_req_t q;
        for (int i = 0; i < n; i++)
        begin
            q.kind = req_type_t'($urandom_range(0, 3));
            for (int k = 0; k < 3; k++)
            begin
                q.a[k] = rand_coord();
                // most boxes are well formed: max sits above min by a random span
                if (q.kind == REQ_BOX && $urandom_range(0, 7) != 0)
                    q.b[k] = q.a[k] + CW'($urandom_range(0, 1 << $urandom_range(0, 22)));
                else
                    q.b[k] = rand_coord();
            end
            q.last = ($urandom_range(0, 7) == 0);
            req_backlog.push_back(q);
        end
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (req_backlog.size() != 0 || s_tvalid || predicted_results.size() != 0);
    endtask

    task automatic cfg_write(cfg_reg_t idx, logic [CFGW-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_SCALE:    cur_scale = val[SCALE_W-1:0];
            CFG_ROT_ROW0: cur_rot[0] = val[3*RW-1:0];
            CFG_ROT_ROW1: cur_rot[1] = val[3*RW-1:0];
            CFG_ROT_ROW2: cur_rot[2] = val[3*RW-1:0];
            CFG_TRANS_X:  cur_trans[0] = val[CW-1:0];
            CFG_TRANS_Y:  cur_trans[1] = val[CW-1:0];
            CFG_TRANS_Z:  cur_trans[2] = val[CW-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [SCALE_W-1:0] sc, logic [CFGW-1:0] r0,
                              logic [CFGW-1:0] r1, logic [CFGW-1:0] r2,
                              logic [CW-1:0] tx, logic [CW-1:0] ty, logic [CW-1:0] tz);
        cfg_write(CFG_SCALE, CFGW'(sc));
        cfg_write(CFG_ROT_ROW0, r0);
        cfg_write(CFG_ROT_ROW1, r1);
        cfg_write(CFG_ROT_ROW2, r2);
        cfg_write(CFG_TRANS_X, CFGW'(tx));
        cfg_write(CFG_TRANS_Y, CFGW'(ty));
        cfg_write(CFG_TRANS_Z, CFGW'(tz));
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        setting_count++;
    endtask

    task automatic pick_idling();
        case ($urandom_range(0, 2))
            0: gap_odds = 0;
            1: gap_odds = 4;
            default: gap_odds = 12;
        endcase
        case ($urandom_range(0, 2))
            0: snk_odds = 0;
            1: snk_odds = 4;
            default: snk_odds = 12;
        endcase
    endtask

    task automatic random_setting(bit wide);
        set_config(($urandom_range(0, 1) == 1) ? SCALE_W'($urandom_range(0, 1024))
                                               : SCALE_W'($urandom),
                   pack_row(rand_rot_entry(wide), rand_rot_entry(wide), rand_rot_entry(wide)),
                   pack_row(rand_rot_entry(wide), rand_rot_entry(wide), rand_rot_entry(wide)),
                   pack_row(rand_rot_entry(wide), rand_rot_entry(wide), rand_rot_entry(wide)),
                   rand_coord(), rand_coord(), rand_coord());
    endtask

    // ------------------------------------------------------------------
    // input driver: change on the falling edge, hold until taken
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            src_gap = 0;
        end
        else if (s_tvalid && !in_fire)
        begin
            // hold the offered item
        end
        else if (src_gap > 0)
        begin
            src_gap--;
            s_tvalid <= 1'b0;
        end
        else if (gap_odds > 0 && $urandom_range(1, gap_odds) == 1)
        begin
            src_gap = $urandom_range(1, 9) - 1;
            s_tvalid <= 1'b0;
        end
        else if (req_backlog.size() != 0)
        begin
            next_req = req_backlog.pop_front();
            s_tvalid <= 1'b1;
            s_tdata  <= DW'({next_req.b, next_req.a});
            s_tuser  <= next_req.kind;
            s_tlast  <= next_req.last;
        end
        else
        begin
            s_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // output ready: random stalls plus one long hold-off
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (!backlog_done && items_accepted >= 400)
            begin
                hold_left = 80;
                backlog_done = 1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (snk_gap > 0)
            begin
                snk_gap--;
                m_tready <= 1'b0;
            end
            else if (snk_odds > 0 && $urandom_range(1, snk_odds) == 1)
            begin
                snk_gap = $urandom_range(1, 9) - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: predict on input accept, compare on output accept
    // ------------------------------------------------------------------
    task automatic check_field(string label, logic [CW-1:0] exp_v, logic [CW-1:0] got_v);
        if (exp_v !== got_v)
        begin
            mismatch_count++;
            $display("%t: %s mismatch, expected %0d, got %0d", $time, label,
                     $signed(exp_v), $signed(got_v));
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_fire <= 1'b0;
        end
        else
        begin
            in_fire <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
            begin
                seen_req.kind = req_type_t'(s_tuser);
                seen_req.a = s_tdata[3*CW-1:0];
                seen_req.b = s_tdata[6*CW-1:3*CW];
                seen_req.last = s_tlast;
                predicted_results.push_back(predict_xform(seen_req));
                items_accepted++;
                if (seen_req.kind == REQ_BOX)
                    box_count++;
            end
            if (m_tvalid && m_tready)
            begin
                seen_res.lo = m_tdata[3*CW-1:0];
                seen_res.hi = m_tdata[6*CW-1:3*CW];
                seen_res.clipped = m_tuser;
                seen_res.last = m_tlast;
                results_seen++;
                if (m_tuser)
                    clipped_count++;
                if (predicted_results.size() == 0)
                begin
                    mismatch_count++;
                    $display("%t: unexpected item on output, expected none, got %h", $time,
                             m_tdata);
                end
                else
                begin
                    want_res = predicted_results.pop_front();
                    for (int k = 0; k < 3; k++)
                    begin
                        check_field($sformatf("out_a_%c", axis_tag[k]), want_res.lo[k],
                                    seen_res.lo[k]);
                        check_field($sformatf("out_b_%c", axis_tag[k]), want_res.hi[k],
                                    seen_res.hi[k]);
                    end
                    check_field("clipped", CW'(want_res.clipped), CW'(seen_res.clipped));
                    check_field("last_out", CW'(want_res.last), CW'(seen_res.last));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin
        cur_scale = SCALE_RESET;
        cur_rot[0] = pack_row(ONE, 0, 0);
        cur_rot[1] = pack_row(0, ONE, 0);
        cur_rot[2] = pack_row(0, 0, ONE);
        for (int k = 0; k < 3; k++)
            cur_trans[k] = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: identity path, extremes and every request type
        gap_odds = 4;
        snk_odds = 4;
        add_item(REQ_POINT, '0, '0, '0, '0, '0, '0, 1'b0);
        add_item(REQ_POINT, C_MAX, C_MAX, C_MAX, '0, '0, '0, 1'b0);
        add_item(REQ_POINT, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 1'b1);
        add_item(REQ_VECTOR, CW'(256), CW'(-256), CW'(512), '0, '0, '0, 1'b0);
        add_item(REQ_DIRECTION, C_MAX, C_MIN, CW'(1), '0, '0, '0, 1'b0);
        add_item(REQ_BOX, CW'(-256), CW'(-256), CW'(-256), CW'(256), CW'(256), CW'(256), 1'b0);
        add_item(REQ_BOX, CW'(100), '0, '0, CW'(-100), '0, '0, 1'b0);
        add_item(REQ_BOX, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 1'b1);
        wait_drained();

        // quarter turn about z, scale 2.0: rotated path, inverted box, overflow
        set_config(SCALE_W'(512), pack_row(0, ONE, 0), pack_row(-ONE, 0, 0),
                   pack_row(0, 0, ONE), CW'(1000), CW'(-1000), C_MAX);
        add_item(REQ_POINT, CW'(256), CW'(512), CW'(768), '0, '0, '0, 1'b0);
        add_item(REQ_POINT, C_MAX, '0, '0, '0, '0, '0, 1'b0);
        add_item(REQ_VECTOR, C_MIN, C_MIN, C_MIN, '0, '0, '0, 1'b0);
        add_item(REQ_DIRECTION, CW'(1), CW'(-1), '0, '0, '0, '0, 1'b0);
        add_item(REQ_BOX, CW'(-300), CW'(10), CW'(-5), CW'(700), CW'(20), CW'(5), 1'b0);
        add_item(REQ_BOX, CW'(700), CW'(20), CW'(5), CW'(-300), CW'(10), CW'(-5), 1'b0);
        add_item(REQ_BOX, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 1'b0);
        add_item(REQ_POINT, CW'(-1), CW'(-1), CW'(-1), '0, '0, '0, 1'b0);
        add_item(REQ_POINT, CW'(1), CW'(1), CW'(1), '0, '0, '0, 1'b0);
        add_item(REQ_DIRECTION, '0, '0, '0, '0, '0, '0, 1'b1);
        wait_drained();

        // largest scale, identity rotation, largest translation
        set_config(16'hFFFF, pack_row(ONE, 0, 0), pack_row(0, ONE, 0), pack_row(0, 0, ONE),
                   C_MAX, C_MAX, C_MAX);
        pick_idling();
        add_random_items(200);
        wait_drained();

        // zero scale: scaled items collapse to the translation
        set_config('0, pack_row(0, ONE, 0), pack_row(-ONE, 0, 0), pack_row(0, 0, ONE),
                   C_MIN, C_MIN, C_MIN);
        pick_idling();
        add_random_items(200);
        wait_drained();

        for (int p = 0; p < 4; p++)
        begin
            random_setting(p[0]);
            pick_idling();
            add_random_items(200);
            wait_drained();
        end

        // just inside the identity test
        set_config(SCALE_W'($urandom), pack_row(ONE - 1, rand_rot_entry(0), rand_rot_entry(0)),
                   pack_row(rand_rot_entry(0), ONE - 1, rand_rot_entry(0)),
                   pack_row(rand_rot_entry(0), rand_rot_entry(0), rand_rot_entry(0)),
                   rand_coord(), rand_coord(), rand_coord());
        pick_idling();
        add_random_items(150);
        wait_drained();

        // just outside it: R00 at the threshold itself
        set_config(SCALE_W'($urandom_range(0, 1024)),
                   pack_row(ONE - 2, rand_rot_entry(0), rand_rot_entry(0)),
                   pack_row(rand_rot_entry(0), 32767, rand_rot_entry(0)),
                   pack_row(rand_rot_entry(0), rand_rot_entry(0), rand_rot_entry(0)),
                   rand_coord(), rand_coord(), rand_coord());
        pick_idling();
        add_random_items(150);
        wait_drained();

        // extreme rotation entries, not orthonormal
        set_config(SCALE_W'(256), pack_row(-32768, 32767, -32768),
                   pack_row(32767, -32768, 32767), pack_row(-32768, -32768, 32767),
                   '0, C_MAX, C_MIN);
        pick_idling();
        add_random_items(150);
        wait_drained();

        // final stretch with both sides always ready
        random_setting(1'b0);
        gap_odds = 0;
        snk_odds = 0;
        add_random_items(200);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d items (%0d boxes) over %0d register settings.",
                 items_accepted, box_count, setting_count);
        $display("Checked %0d results, %0d of them saturated; %0d field mismatches.",
                 results_seen, clipped_count, mismatch_count);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[similarity_transform_unit.f]
+incdir+rtl
rtl/stu_pkg.sv
rtl/stu_scale_lane.sv
rtl/stu_rot_lane.sv
rtl/stu_merge.sv
rtl/similarity_transform_unit.sv
tb/sv/tb_similarity_transform_unit.sv
